>>> hw/rtl/bsc_pkg.sv
// Shared types, codes and sizing helpers for the banker's safety check block.
// No dependencies; every other file of the block imports this package.
package bsc_pkg;

    localparam int DEF_MAX_PROCS = 8;
    localparam int DEF_NUM_RES   = 3;
    localparam int HW_ROW_LIMIT  = 8;   // proc_index is three bits wide
    localparam int CNT_W         = 8;
    localparam int PCNT_W        = 4;
    localparam logic [PCNT_W-1:0] PCNT_RESET = 4'd5;

    typedef logic [CNT_W-1:0] t_cnt;

    localparam logic [1:0] MODE_LOAD_FREE = 2'd0;
    localparam logic [1:0] MODE_LOAD_ROW  = 2'd1;
    localparam logic [1:0] MODE_RUN       = 2'd2;

    localparam logic [1:0] ST_GRANT  = 2'd0;
    localparam logic [1:0] ST_SAFE   = 2'd1;
    localparam logic [1:0] ST_UNSAFE = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] proc_index;
        t_cnt       amount_a;
        t_cnt       amount_b;
        t_cnt       amount_c;
        t_cnt       limit_a;
        t_cnt       limit_b;
        t_cnt       limit_c;
    } t_in_item;

    typedef struct packed {
        logic [2:0] granted_proc;
        logic [1:0] status;
        logic       last;
    } t_out_item;

    typedef enum logic [0:0] {
        S_IDLE,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic busy;
        logic grant;   // row at scan index is granted this cycle
        logic done;    // pass ended with no grant, run finishes
        logic safe;    // no row left pending
    } t_ctrl;

    function automatic int row_count(int max_procs);
        return (max_procs < HW_ROW_LIMIT) ? max_procs : HW_ROW_LIMIT;
    endfunction

    function automatic int row_idx_w(int rows);
        return (rows > 1) ? $clog2(rows) : 1;
    endfunction

    function automatic t_cnt pick3(int j, t_cnt a, t_cnt b, t_cnt c);
        t_cnt v;
        case (j)
            0:       v = a;
            1:       v = b;
            default: v = c;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/bankers_safety_check_unit.sv
// Banker's safety check top level: free counts, row store, compare unit, sequencer.
// Depends on bsc_pkg, bsc_row_store, bsc_fit_unit and bsc_ctrl.
//
// Usage: drive i_in and raise start; the item transfers on a rising edge with
// start high and busy low. Mode 0 loads the free counts and mode 1 loads one
// process row; both take effect at that edge, give no result and leave busy low.
// Mode 2 runs the check: busy rises and the sequencer tests one row per cycle in
// the shared compare unit, restarting at row 0 after every grant. A grant result
// is on the ports in the cycle right after the compare that found the row; the
// final result (safe or unsafe, last set) follows the first full pass with no
// grant, on the cycle busy drops. Each result holds the o_out ports for exactly one
// cycle with o_valid high; the receiver cannot stall, so no result is ever held
// back. The user must write the process count with i_cfg_we only while idle;
// the block itself does not enforce it.
// Reset (i_rst_n low, synchronous) clears free counts, the pending set and the
// sequencer and sets the process count to 5; row contents are not cleared.
module bankers_safety_check_unit #(
    parameter int MAX_PROCS     = bsc_pkg::DEF_MAX_PROCS,
    parameter int NUM_RESOURCES = bsc_pkg::DEF_NUM_RES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  bsc_pkg::t_in_item          i_in,
    output logic                       o_valid,
    output bsc_pkg::t_out_item         o_out,
    input  logic                       i_cfg_we,
    input  logic [bsc_pkg::PCNT_W-1:0] i_cfg_wdata
);
    import bsc_pkg::*;

    localparam int ROWS   = row_count(MAX_PROCS);
    localparam int ROW_IW = row_idx_w(ROWS);

    logic [PCNT_W-1:0] r_proc_count;
    logic [PCNT_W-1:0] eff_count;
    t_cnt              r_free [NUM_RESOURCES];
    t_cnt              n_free [NUM_RESOURCES];
    t_cnt              amt    [NUM_RESOURCES];
    t_cnt              lim    [NUM_RESOURCES];
    t_cnt              rd_held  [NUM_RESOURCES];
    t_cnt              rd_limit [NUM_RESOURCES];
    logic              r_valid;
    t_out_item         r_out;
    logic              accept;
    logic              load_free;
    logic              load_row;
    logic              run;
    logic              fit;
    logic [ROW_IW-1:0] scan_idx;
    t_ctrl             ctrl;

    assign accept    = start && !busy;
    assign load_free = accept && (i_in.mode == MODE_LOAD_FREE);
    assign load_row  = accept && (i_in.mode == MODE_LOAD_ROW)
                     && ({1'b0, i_in.proc_index} < PCNT_W'(ROWS));
    assign run       = accept && (i_in.mode == MODE_RUN);

    assign eff_count = (r_proc_count > PCNT_W'(ROWS)) ? PCNT_W'(ROWS) : r_proc_count;

    always_comb begin
        for (int j = 0; j < NUM_RESOURCES; j++) begin
            amt[j] = pick3(j, i_in.amount_a, i_in.amount_b, i_in.amount_c);
            lim[j] = pick3(j, i_in.limit_a, i_in.limit_b, i_in.limit_c);
        end
    end

    bsc_row_store #(
        .MAX_PROCS     (MAX_PROCS),
        .NUM_RESOURCES (NUM_RESOURCES),
        .ROW_IW        (ROW_IW)
    ) u_store (
        .i_clk      (i_clk),
        .i_we       (load_row),
        .i_widx     (i_in.proc_index[ROW_IW-1:0]),
        .i_wr_held  (amt),
        .i_wr_limit (lim),
        .i_clr      (ctrl.grant),
        .i_cidx     (scan_idx),
        .i_ridx     (scan_idx),
        .o_held     (rd_held),
        .o_limit    (rd_limit)
    );

    bsc_fit_unit #(
        .NUM_RESOURCES (NUM_RESOURCES)
    ) u_fit (
        .i_held  (rd_held),
        .i_limit (rd_limit),
        .i_free  (r_free),
        .o_fit   (fit)
    );

    bsc_ctrl #(
        .MAX_PROCS (MAX_PROCS),
        .ROW_IW    (ROW_IW)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_run   (run),
        .i_count (eff_count),
        .i_fit   (fit),
        .o_idx   (scan_idx),
        .o_ctrl  (ctrl)
    );

    assign busy = ctrl.busy;

    // free counts: load, or take back a granted row's holdings saturating at 255
    always_comb begin
        logic [CNT_W:0] sum;
        sum = '0;
        for (int j = 0; j < NUM_RESOURCES; j++) begin
            n_free[j] = r_free[j];
            if (load_free) begin
                n_free[j] = amt[j];
            end else if (ctrl.grant) begin
                sum       = {1'b0, r_free[j]} + {1'b0, rd_held[j]};
                n_free[j] = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proc_count <= PCNT_RESET;
            r_valid      <= 1'b0;
            for (int j = 0; j < NUM_RESOURCES; j++) begin
                r_free[j] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_proc_count <= i_cfg_wdata;
            end
            r_valid <= ctrl.grant || ctrl.done;
            r_free  <= n_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.grant) begin
            r_out.granted_proc <= 3'(scan_idx);
            r_out.status       <= ST_GRANT;
            r_out.last         <= 1'b0;
        end else if (ctrl.done) begin
            r_out.granted_proc <= '0;
            r_out.status       <= ctrl.safe ? ST_SAFE : ST_UNSAFE;
            r_out.last         <= 1'b1;
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule

>>> hw/rtl/bsc_row_store.sv
// Held and maximum counts for each process row, one write, one clear, one read port.
// Depends on bsc_pkg. Contents are undefined until a row is written.
module bsc_row_store #(
    parameter int MAX_PROCS     = bsc_pkg::DEF_MAX_PROCS,
    parameter int NUM_RESOURCES = bsc_pkg::DEF_NUM_RES,
    parameter int ROW_IW        = bsc_pkg::row_idx_w(bsc_pkg::row_count(MAX_PROCS))
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ROW_IW-1:0] i_widx,
    input  bsc_pkg::t_cnt     i_wr_held  [NUM_RESOURCES],
    input  bsc_pkg::t_cnt     i_wr_limit [NUM_RESOURCES],
    input  logic              i_clr,
    input  logic [ROW_IW-1:0] i_cidx,
    input  logic [ROW_IW-1:0] i_ridx,
    output bsc_pkg::t_cnt     o_held     [NUM_RESOURCES],
    output bsc_pkg::t_cnt     o_limit    [NUM_RESOURCES]
);
    import bsc_pkg::*;

    localparam int ROWS = row_count(MAX_PROCS);

    t_cnt r_held  [ROWS][NUM_RESOURCES];
    t_cnt r_limit [ROWS][NUM_RESOURCES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_held[i_widx]  <= i_wr_held;
            r_limit[i_widx] <= i_wr_limit;
        end else if (i_clr) begin
            // granted row hands its holdings back
            for (int j = 0; j < NUM_RESOURCES; j++) begin
                r_held[i_cidx][j] <= '0;
            end
        end
    end

    assign o_held  = r_held[i_ridx];
    assign o_limit = r_limit[i_ridx];

endmodule

>>> hw/rtl/bsc_fit_unit.sv
// Shared compare unit: does one row's need fit the free counts in every resource.
// Depends on bsc_pkg.
module bsc_fit_unit #(
    parameter int NUM_RESOURCES = bsc_pkg::DEF_NUM_RES
) (
    input  bsc_pkg::t_cnt i_held  [NUM_RESOURCES],
    input  bsc_pkg::t_cnt i_limit [NUM_RESOURCES],
    input  bsc_pkg::t_cnt i_free  [NUM_RESOURCES],
    output logic          o_fit
);
    import bsc_pkg::*;

    always_comb begin
        t_cnt need;
        o_fit = 1'b1;
        for (int j = 0; j < NUM_RESOURCES; j++) begin
            need = i_limit[j] - i_held[j];
            // maximum below held never fits
            if (i_limit[j] < i_held[j] || need > i_free[j]) begin
                o_fit = 1'b0;
            end
        end
    end

endmodule

>>> hw/rtl/bsc_ctrl.sv
// Run sequencer: pending mask, scan index and grant/finish decisions.
// Depends on bsc_pkg; drives the row store read index and the result strobes.
module bsc_ctrl #(
    parameter int MAX_PROCS = bsc_pkg::DEF_MAX_PROCS,
    parameter int ROW_IW    = bsc_pkg::row_idx_w(bsc_pkg::row_count(MAX_PROCS))
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_run,
    input  logic [bsc_pkg::PCNT_W-1:0] i_count,
    input  logic                       i_fit,
    output logic [ROW_IW-1:0]          o_idx,
    output bsc_pkg::t_ctrl             o_ctrl
);
    import bsc_pkg::*;

    localparam int ROWS = row_count(MAX_PROCS);

    t_state            r_state, n_state;
    logic [ROW_IW-1:0] r_idx, n_idx;
    logic [ROWS-1:0]   r_pend, n_pend;
    logic              hit;
    logic              pass_end;

    assign hit      = r_pend[r_idx] && i_fit;
    assign pass_end = (PCNT_W'(r_idx) + PCNT_W'(1)) >= i_count;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_pend  = r_pend;
        case (r_state)
            S_IDLE: begin
                if (i_run) begin
                    n_state = S_SCAN;
                    n_idx   = '0;
                    for (int r = 0; r < ROWS; r++) begin
                        n_pend[r] = PCNT_W'(r) < i_count;
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_pend[r_idx] = 1'b0;
                    n_idx         = '0;    // rescan from the lowest row
                end else if (pass_end) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + ROW_IW'(1);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl.busy  = (r_state == S_SCAN);
        o_ctrl.grant = (r_state == S_SCAN) && hit;
        o_ctrl.done  = (r_state == S_SCAN) && !hit && pass_end;
        o_ctrl.safe  = (r_pend == '0);
    end

    assign o_idx = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_pend  <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
        end
    end

    a_grant_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ctrl.grant && o_ctrl.done))
        else $error("grant and finish in the same cycle");

    a_grant_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.grant |=> (r_idx == '0) && o_ctrl.busy)
        else $error("scan did not restart after a grant");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.done |=> !o_ctrl.busy)
        else $error("sequencer still busy after run finished");

    a_pend_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctrl.busy && $past(o_ctrl.busy))
            |-> ($countones(r_pend) <= $countones($past(r_pend))))
        else $error("pending set grew during a run");

endmodule
